// ===== sv/irpdt_pkg.sv =====
package irpdt_pkg;

	localparam int DATA_BITS_DEF = 8;
	localparam int DATA_W        = 8;
	localparam int TICK_W        = 8;
	localparam int CFG_IDX_W     = 3;

	localparam logic [CFG_IDX_W-1:0] CFG_LEADER_MARK  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_LEADER_SPACE = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_BIT_MARK     = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_ONE_SPACE    = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_ZERO_SPACE   = 3'd4;

	localparam logic [TICK_W-1:0] RST_LEADER_MARK  = 8'd90;
	localparam logic [TICK_W-1:0] RST_LEADER_SPACE = 8'd90;
	localparam logic [TICK_W-1:0] RST_BIT_MARK     = 8'd6;
	localparam logic [TICK_W-1:0] RST_ONE_SPACE    = 8'd18;
	localparam logic [TICK_W-1:0] RST_ZERO_SPACE   = 8'd6;

	typedef enum logic [2:0] {
		PH_IDLE       = 3'd0,
		PH_LEAD_MARK  = 3'd1,
		PH_LEAD_SPACE = 3'd2,
		PH_BIT_MARK   = 3'd3,
		PH_BIT_SPACE  = 3'd4
	} phase_t;

	typedef struct packed {
		logic [TICK_W-1:0] leader_mark;
		logic [TICK_W-1:0] leader_space;
		logic [TICK_W-1:0] bit_mark;
		logic [TICK_W-1:0] one_space;
		logic [TICK_W-1:0] zero_space;
	} timing_t;

	typedef struct packed {
		logic line_level;
		logic busy_res;
		logic frame_done;
	} result_t;

	// a zero length still lasts one tick
	function automatic logic [TICK_W-1:0] seg_len(input logic [TICK_W-1:0] r);
		seg_len = (r == '0) ? TICK_W'(1) : r;
	endfunction

endpackage

// ===== sv/irpdt_cfg.sv =====
module irpdt_cfg (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [irpdt_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [irpdt_pkg::TICK_W-1:0]    cfg_data,
	output irpdt_pkg::timing_t              timing
);

	irpdt_pkg::timing_t timing_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			timing_q.leader_mark  <= irpdt_pkg::RST_LEADER_MARK;
			timing_q.leader_space <= irpdt_pkg::RST_LEADER_SPACE;
			timing_q.bit_mark     <= irpdt_pkg::RST_BIT_MARK;
			timing_q.one_space    <= irpdt_pkg::RST_ONE_SPACE;
			timing_q.zero_space   <= irpdt_pkg::RST_ZERO_SPACE;
		end else if (cfg_we) begin
			case (cfg_index)
				irpdt_pkg::CFG_LEADER_MARK:  timing_q.leader_mark  <= cfg_data;
				irpdt_pkg::CFG_LEADER_SPACE: timing_q.leader_space <= cfg_data;
				irpdt_pkg::CFG_BIT_MARK:     timing_q.bit_mark     <= cfg_data;
				irpdt_pkg::CFG_ONE_SPACE:    timing_q.one_space    <= cfg_data;
				irpdt_pkg::CFG_ZERO_SPACE:   timing_q.zero_space   <= cfg_data;
				default: ;
			endcase
		end
	end

	assign timing = timing_q;

endmodule

// ===== sv/irpdt_seq.sv =====
module irpdt_seq #(
	parameter int DATA_BITS = irpdt_pkg::DATA_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  irpdt_pkg::timing_t            timing,
	input  logic                          en,
	input  logic                          action,
	input  logic [irpdt_pkg::DATA_W-1:0]  data_byte,
	output irpdt_pkg::result_t            res
);

	localparam int POS_W = (DATA_BITS > 1) ? $clog2(DATA_BITS) : 1;
	localparam logic [POS_W-1:0] LAST_POS = POS_W'(DATA_BITS - 1);

	irpdt_pkg::phase_t                 phase_q, phase_d;
	logic [irpdt_pkg::TICK_W-1:0]      ticks_q, ticks_d, ticks_dec;
	logic [POS_W-1:0]                  pos_q, pos_d;
	logic [irpdt_pkg::DATA_W-1:0]      shift_q, shift_d;
	logic                              done_d;

	// next state
	always_comb begin
		phase_d   = phase_q;
		ticks_d   = ticks_q;
		pos_d     = pos_q;
		shift_d   = shift_q;
		done_d    = 1'b0;
		ticks_dec = (ticks_q != '0) ? ticks_q - 1'b1 : ticks_q;
		if (action) begin
			if (phase_q == irpdt_pkg::PH_IDLE) begin
				shift_d = data_byte;
				pos_d   = '0;
				phase_d = irpdt_pkg::PH_LEAD_MARK;
				ticks_d = irpdt_pkg::seg_len(timing.leader_mark);
			end
		end else if (phase_q != irpdt_pkg::PH_IDLE) begin
			ticks_d = ticks_dec;
			if (ticks_dec == '0) begin
				case (phase_q)
					irpdt_pkg::PH_LEAD_MARK: begin
						phase_d = irpdt_pkg::PH_LEAD_SPACE;
						ticks_d = irpdt_pkg::seg_len(timing.leader_space);
					end
					irpdt_pkg::PH_LEAD_SPACE: begin
						phase_d = irpdt_pkg::PH_BIT_MARK;
						ticks_d = irpdt_pkg::seg_len(timing.bit_mark);
					end
					irpdt_pkg::PH_BIT_MARK: begin
						phase_d = irpdt_pkg::PH_BIT_SPACE;
						ticks_d = shift_q[0] ? irpdt_pkg::seg_len(timing.one_space)
						                     : irpdt_pkg::seg_len(timing.zero_space);
					end
					default: begin
						shift_d = shift_q >> 1;
						if (pos_q == LAST_POS) begin
							phase_d = irpdt_pkg::PH_IDLE;
							ticks_d = '0;
							pos_d   = '0;
							done_d  = 1'b1;
						end else begin
							pos_d   = pos_q + 1'b1;
							phase_d = irpdt_pkg::PH_BIT_MARK;
							ticks_d = irpdt_pkg::seg_len(timing.bit_mark);
						end
					end
				endcase
			end
		end
	end

	// result of this item
	always_comb begin
		res.line_level = (phase_d == irpdt_pkg::PH_LEAD_MARK) ||
		                 (phase_d == irpdt_pkg::PH_BIT_MARK);
		res.busy_res   = (phase_d != irpdt_pkg::PH_IDLE);
		res.frame_done = done_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= irpdt_pkg::PH_IDLE;
			ticks_q <= '0;
			pos_q   <= '0;
			shift_q <= '0;
		end else if (en) begin
			phase_q <= phase_d;
			ticks_q <= ticks_d;
			pos_q   <= pos_d;
			shift_q <= shift_d;
		end
	end

endmodule

// ===== sv/ir_pulse_distance_transmitter.sv =====
// Infrared pulse-distance transmitter stepped by timer ticks. Each item is
// either a tick (action 0) or a send request (action 1) carrying data_byte;
// a send is taken only while idle and starts a frame of leader mark, leader
// space and DATA_BITS bits sent LSB first, each a fixed mark and a space
// whose length depends on the bit. A send while busy is ignored. Every item
// yields one result: line level, busy flag and a frame-done pulse on the
// tick that ends the last bit space. Segment lengths are set by five 8-bit
// registers written through cfg_we/cfg_index/cfg_data; the user must write
// them only while idle, which the block does not enforce. A length of zero
// counts as one tick. An item passes an input register and the frame
// sequencer into the result register; one item is taken every cycle while res_ready stays high.
module ir_pulse_distance_transmitter #(
	parameter int DATA_BITS = irpdt_pkg::DATA_BITS_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [irpdt_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [irpdt_pkg::TICK_W-1:0]    cfg_data,
	input  logic                            item_valid,
	output logic                            item_ready,
	input  logic                            action,
	input  logic [irpdt_pkg::DATA_W-1:0]    data_byte,
	output logic                            res_valid,
	input  logic                            res_ready,
	output logic                            line_level,
	output logic                            busy_res,
	output logic                            frame_done
);

	irpdt_pkg::timing_t           timing;
	irpdt_pkg::result_t           res;
	irpdt_pkg::result_t           res_q;
	logic                         valid_s1;
	logic                         action_s1;
	logic [irpdt_pkg::DATA_W-1:0] data_s1;
	logic                         res_valid_q;
	logic                         adv;

	assign adv        = valid_s1 && (!res_valid_q || res_ready);
	assign item_ready = !valid_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (item_valid && item_ready) begin
			valid_s1 <= 1'b1;
		end else if (adv) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (item_valid && item_ready) begin
			action_s1 <= action;
			data_s1   <= data_byte;
		end
	end

	irpdt_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.timing    (timing)
	);

	irpdt_seq #(
		.DATA_BITS (DATA_BITS)
	) u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.timing    (timing),
		.en        (adv),
		.action    (action_s1),
		.data_byte (data_s1),
		.res       (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (adv) begin
			res_valid_q <= 1'b1;
		end else if (res_ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			res_q <= res;
		end
	end

	assign res_valid  = res_valid_q;
	assign line_level = res_q.line_level;
	assign busy_res   = res_q.busy_res;
	assign frame_done = res_q.frame_done;

endmodule
